/* src/stepper_job_pulse_controller_core_assert.svh */
// Assertion macros for the stepper job pulse controller.
`ifndef STEPPER_JOB_PULSE_CONTROLLER_CORE_ASSERT_SVH
`define STEPPER_JOB_PULSE_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define SJPC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sjpc check failed");
// Trigger in one cycle implies the condition in the next cycle.
`define SJPC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sjpc check failed");
`else
`define SJPC_ASSERT_ALWAYS(lbl, cond)
`define SJPC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

/* src/sjpc_pkg.sv */
// Types, codes and shift tables shared by the stepper job pulse controller.
`default_nettype none

package sjpc_pkg;

    typedef enum logic [1:0] {
        FUNC_START,
        FUNC_COMPARE,
        FUNC_STALL,
        FUNC_CLEAR
    } func_t;

    typedef enum logic [1:0] {
        END_COUNT,
        END_STALL,
        END_FOREVER,
        END_IMMEDIATE
    } end_kind_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_FIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        FIT_IDLE,
        FIT_DIV,
        FIT_SHIFT
    } fit_state_t;

    localparam int NUM_AXES = 4;

    localparam int QUOT_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int CODE_W   = 3;

    // Axis with the 8-bit timer and no step pin.
    localparam logic [1:0] NARROW_AXIS = 2'd3;
    // Axes below this one honor stall events.
    localparam logic [1:0] STALL_AXES  = 2'd2;

    localparam logic [QUOT_W-1:0] WIDE_MAX   = 32'h0000FFFF;
    localparam logic [QUOT_W-1:0] NARROW_MAX = 32'h000000FF;

    typedef struct packed {
        logic                busy;
        logic [CODE_W-1:0]   code;
        logic [PERIOD_W-1:0] period;
    } fit_status_t;

    // Shift step taken when moving past prescaler code k; zero ends the search.
    function automatic logic [1:0] shift_amt(input logic narrow, input logic [2:0] k);
        logic [1:0] sh;
        sh = 2'd0;
        if (narrow) begin
            case (k)
                3'd0:    sh = 2'd1;
                3'd1:    sh = 2'd3;
                3'd2:    sh = 2'd2;
                3'd3:    sh = 2'd1;
                3'd4:    sh = 2'd1;
                3'd5:    sh = 2'd1;
                3'd6:    sh = 2'd2;
                default: sh = 2'd0;
            endcase
        end
        else begin
            case (k)
                3'd0:    sh = 2'd1;
                3'd1:    sh = 2'd3;
                3'd2:    sh = 2'd3;
                3'd3:    sh = 2'd2;
                3'd4:    sh = 2'd2;
                default: sh = 2'd0;
            endcase
        end
        return sh;
    endfunction

endpackage

`default_nettype wire

/* src/sjpc_fit.sv */
// Clock divider and prescaler search: restoring divide, then one shift step a cycle.
`default_nettype none

module sjpc_fit #(
    parameter int unsigned CLOCK_HZ = 16000000
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          narrow,
    input  wire logic [15:0]                   freq,
    output sjpc_pkg::fit_status_t              status
);

    localparam int CNT_W = $clog2(sjpc_pkg::QUOT_W);

    sjpc_pkg::fit_state_t state_reg, state_next;
    logic [sjpc_pkg::QUOT_W-1:0]   q_reg, q_next;
    logic [15:0]                   rem_reg, rem_next;
    logic [15:0]                   freq_reg, freq_next;
    logic                          narrow_reg, narrow_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [2:0]                    k_reg, k_next;
    logic [sjpc_pkg::CODE_W-1:0]   code_reg, code_next;

    logic [16:0]                   trial;
    logic [16:0]                   diff;
    logic                          ge;
    logic [1:0]                    sh;
    logic                          over;
    logic [sjpc_pkg::QUOT_W-1:0]   rounded;

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        freq_next   = freq_reg;
        narrow_next = narrow_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        code_next   = code_reg;

        trial = {rem_reg, q_reg[sjpc_pkg::QUOT_W-1]};
        diff  = trial - {1'b0, freq_reg};
        ge    = trial >= {1'b0, freq_reg};

        sh   = sjpc_pkg::shift_amt(narrow_reg, k_reg);
        over = narrow_reg ? (q_reg[sjpc_pkg::QUOT_W-1:8] != '0)
                          : (q_reg[sjpc_pkg::QUOT_W-1:16] != '0);

        // Round to nearest: add back the last bit shifted out.
        case (sh)
            2'd1:    rounded = (q_reg >> 1) + {{(sjpc_pkg::QUOT_W-1){1'b0}}, q_reg[0]};
            2'd2:    rounded = (q_reg >> 2) + {{(sjpc_pkg::QUOT_W-1){1'b0}}, q_reg[1]};
            2'd3:    rounded = (q_reg >> 3) + {{(sjpc_pkg::QUOT_W-1){1'b0}}, q_reg[2]};
            default: rounded = q_reg;
        endcase

        case (state_reg)
            sjpc_pkg::FIT_IDLE:
            begin
                if (start)
                begin
                    q_next      = sjpc_pkg::QUOT_W'(CLOCK_HZ);
                    rem_next    = '0;
                    cnt_next    = '0;
                    freq_next   = freq;
                    narrow_next = narrow;
                    state_next  = sjpc_pkg::FIT_DIV;
                end
            end
            sjpc_pkg::FIT_DIV:
            begin
                rem_next = ge ? diff[15:0] : trial[15:0];
                q_next   = {q_reg[sjpc_pkg::QUOT_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(sjpc_pkg::QUOT_W - 1))
                begin
                    k_next     = 3'd1;
                    state_next = sjpc_pkg::FIT_SHIFT;
                end
            end
            sjpc_pkg::FIT_SHIFT:
            begin
                if (!over || sh == 2'd0)
                begin
                    // Saturate when the last prescaler still leaves it too wide.
                    if (over)
                    begin
                        q_next = narrow_reg ? sjpc_pkg::NARROW_MAX : sjpc_pkg::WIDE_MAX;
                    end
                    code_next  = k_reg;
                    state_next = sjpc_pkg::FIT_IDLE;
                end
                else
                begin
                    q_next = rounded;
                    k_next = k_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = sjpc_pkg::FIT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sjpc_pkg::FIT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        freq_reg   <= freq_next;
        narrow_reg <= narrow_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        code_reg   <= code_next;
    end

    assign status.busy   = state_reg != sjpc_pkg::FIT_IDLE;
    assign status.code   = code_reg;
    assign status.period = q_reg[sjpc_pkg::PERIOD_W-1:0];

endmodule

`default_nettype wire

/* src/stepper_job_pulse_controller_core.sv */
// Four-axis step job controller with timer prescaler selection.
//
// Requests enter on in_valid/in_ready: start job, compare event, stall
// event or clear all axes. Every request gives exactly one result on
// out_valid/out_ready, held in an output register until taken.
// Compare, stall, clear and starts that do not run: the result is
// registered at the accepting edge, so out_valid is high right after it
// and such requests can be taken every cycle while out_ready is high.
// A start that runs uses the shared divide/shift unit: a restoring divide
// (one quotient bit a cycle), then prescaler codes tried in turn, up to
// 5 on the wide axes and 7 on the narrow axis; the result is loaded into
// the output register once out_valid is low or out_ready is high.
// in_ready is low while the unit works and while a finished result
// cannot be placed because out_valid is high and out_ready is low; a
// stalled receiver therefore holds the block after at most one result.
// Reset clears all axis state: no axis runs, all step levels are low.
`include "stepper_job_pulse_controller_core_assert.svh"
`default_nettype none

module stepper_job_pulse_controller_core #(
    parameter int unsigned CLOCK_HZ = 16000000
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [1:0]  axis,
    input  wire logic [15:0] frequency,
    input  wire logic [1:0]  end_kind,
    input  wire logic [31:0] step_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             running,
    output logic             step_level,
    output logic [2:0]       prescale_code,
    output logic [15:0]      period,
    output logic             finished
);

    sjpc_pkg::ctrl_state_t ctrl_state_reg, ctrl_state_next;

    logic [sjpc_pkg::NUM_AXES-1:0] running_reg, running_next;
    logic [sjpc_pkg::NUM_AXES-1:0] level_reg, level_next;
    sjpc_pkg::end_kind_t           end_kind_reg [sjpc_pkg::NUM_AXES];
    sjpc_pkg::end_kind_t           end_kind_next [sjpc_pkg::NUM_AXES];
    logic [31:0]                   steps_left_reg [sjpc_pkg::NUM_AXES];
    logic [31:0]                   steps_left_next [sjpc_pkg::NUM_AXES];
    logic [15:0]                   period_reg [sjpc_pkg::NUM_AXES];
    logic [15:0]                   period_next [sjpc_pkg::NUM_AXES];
    logic [2:0]                    prescale_reg [sjpc_pkg::NUM_AXES];
    logic [2:0]                    prescale_next [sjpc_pkg::NUM_AXES];
    logic [1:0]                    cur_axis_reg, cur_axis_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_running_reg, out_running_next;
    logic                          out_level_reg, out_level_next;
    logic [2:0]                    out_code_reg, out_code_next;
    logic [15:0]                   out_period_reg, out_period_next;
    logic                          out_finished_reg, out_finished_next;

    sjpc_pkg::func_t               req_func;
    sjpc_pkg::end_kind_t           req_kind;
    logic                          accept;
    logic                          out_free;
    logic                          run;
    logic                          fin;
    logic                          fit_start;
    logic [31:0]                   dec;
    sjpc_pkg::fit_status_t         fit_status;

    sjpc_fit #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_fit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fit_start),
        .narrow (axis == sjpc_pkg::NARROW_AXIS),
        .freq   (frequency),
        .status (fit_status)
    );

    assign req_func = sjpc_pkg::func_t'(func);
    assign req_kind = sjpc_pkg::end_kind_t'(end_kind);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (ctrl_state_reg == sjpc_pkg::CTRL_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ctrl_state_next   = ctrl_state_reg;
        running_next      = running_reg;
        level_next        = level_reg;
        end_kind_next     = end_kind_reg;
        steps_left_next   = steps_left_reg;
        period_next       = period_reg;
        prescale_next     = prescale_reg;
        cur_axis_next     = cur_axis_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_running_next  = out_running_reg;
        out_level_next    = out_level_reg;
        out_code_next     = out_code_reg;
        out_period_next   = out_period_reg;
        out_finished_next = out_finished_reg;
        fit_start         = 1'b0;
        fin               = 1'b0;
        run               = 1'b0;
        dec               = steps_left_reg[axis] - 32'd1;

        case (ctrl_state_reg)
            sjpc_pkg::CTRL_IDLE:
            begin
                if (accept)
                begin
                    case (req_func)
                        sjpc_pkg::FUNC_START:
                        begin
                            end_kind_next[axis] = req_kind;
                            if (frequency != '0)
                            begin
                                if (req_kind == sjpc_pkg::END_COUNT)
                                begin
                                    if (step_count != '0)
                                    begin
                                        steps_left_next[axis] = step_count;
                                        run = 1'b1;
                                    end
                                end
                                else if (req_kind != sjpc_pkg::END_IMMEDIATE)
                                begin
                                    run = 1'b1;
                                end
                            end
                            running_next[axis] = run;
                        end
                        sjpc_pkg::FUNC_COMPARE:
                        begin
                            if (running_reg[axis])
                            begin
                                if (axis != sjpc_pkg::NARROW_AXIS)
                                begin
                                    level_next[axis] = !level_reg[axis];
                                end
                                if (end_kind_reg[axis] == sjpc_pkg::END_COUNT)
                                begin
                                    steps_left_next[axis] = dec;
                                    if (dec == '0)
                                    begin
                                        running_next[axis] = 1'b0;
                                        fin = 1'b1;
                                    end
                                end
                            end
                        end
                        sjpc_pkg::FUNC_STALL:
                        begin
                            if (axis < sjpc_pkg::STALL_AXES && running_reg[axis] &&
                                end_kind_reg[axis] == sjpc_pkg::END_STALL)
                            begin
                                running_next[axis] = 1'b0;
                                fin = 1'b1;
                            end
                        end
                        sjpc_pkg::FUNC_CLEAR:
                        begin
                            fin          = |running_reg;
                            running_next = '0;
                        end
                        default:
                        begin
                            fin = 1'b0;
                        end
                    endcase

                    if (run)
                    begin
                        // Hold the result until the period search completes.
                        fit_start       = 1'b1;
                        cur_axis_next   = axis;
                        ctrl_state_next = sjpc_pkg::CTRL_FIT;
                    end
                    else
                    begin
                        out_valid_next    = 1'b1;
                        out_finished_next = fin;
                        if (req_func == sjpc_pkg::FUNC_CLEAR)
                        begin
                            out_running_next = 1'b0;
                            out_level_next   = 1'b0;
                            out_code_next    = '0;
                            out_period_next  = '0;
                        end
                        else
                        begin
                            out_running_next = running_next[axis];
                            out_level_next   = level_next[axis];
                            out_code_next    = running_next[axis] ? prescale_reg[axis] : '0;
                            out_period_next  = running_next[axis] ? period_reg[axis] : '0;
                        end
                    end
                end
            end
            sjpc_pkg::CTRL_FIT:
            begin
                if (!fit_status.busy && out_free)
                begin
                    period_next[cur_axis_reg]   = fit_status.period;
                    prescale_next[cur_axis_reg] = fit_status.code;
                    out_valid_next    = 1'b1;
                    out_running_next  = 1'b1;
                    out_level_next    = level_reg[cur_axis_reg];
                    out_code_next     = fit_status.code;
                    out_period_next   = fit_status.period;
                    out_finished_next = 1'b0;
                    ctrl_state_next   = sjpc_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                ctrl_state_next = sjpc_pkg::CTRL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_state_reg <= sjpc_pkg::CTRL_IDLE;
            out_valid_reg  <= 1'b0;
            running_reg    <= '0;
            level_reg      <= '0;
            for (int i = 0; i < sjpc_pkg::NUM_AXES; i++)
            begin
                end_kind_reg[i]   <= sjpc_pkg::END_COUNT;
                steps_left_reg[i] <= '0;
                period_reg[i]     <= '0;
                prescale_reg[i]   <= '0;
            end
        end
        else
        begin
            ctrl_state_reg <= ctrl_state_next;
            out_valid_reg  <= out_valid_next;
            running_reg    <= running_next;
            level_reg      <= level_next;
            end_kind_reg   <= end_kind_next;
            steps_left_reg <= steps_left_next;
            period_reg     <= period_next;
            prescale_reg   <= prescale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_axis_reg     <= cur_axis_next;
        out_running_reg  <= out_running_next;
        out_level_reg    <= out_level_next;
        out_code_reg     <= out_code_next;
        out_period_reg   <= out_period_next;
        out_finished_reg <= out_finished_next;
    end

    assign out_valid     = out_valid_reg;
    assign running       = out_running_reg;
    assign step_level    = out_level_reg;
    assign prescale_code = out_code_reg;
    assign period        = out_period_reg;
    assign finished      = out_finished_reg;

    `SJPC_ASSERT_ALWAYS(a_no_accept_in_fit, !(ctrl_state_reg == sjpc_pkg::CTRL_FIT && in_ready))
    `SJPC_ASSERT_NEXT(a_clear_stops_all, accept && req_func == sjpc_pkg::FUNC_CLEAR, running_reg == '0)
    `SJPC_ASSERT_ALWAYS(a_narrow_no_pin, level_reg[sjpc_pkg::NARROW_AXIS] == 1'b0)
    `SJPC_ASSERT_ALWAYS(a_idle_zero_period, !out_valid_reg || out_running_reg || out_period_reg == '0)

endmodule

`default_nettype wire
